// ===== src/pcfe_pkg.sv =====
package pcfe_pkg;

	// default channel count
	localparam int NumChannelsDef = 8;

	// channels below this index escalate and may have their count cleared
	localparam int EscalateLimit = 5;

	// timed disable deadline that would land on zero is moved here
	localparam logic [31:0] DeadlineFloor = 32'd1;

	// largest fault count
	localparam logic [7:0] CountMax = 8'd255;

	// action codes
	localparam logic [3:0] ACT_NONE      = 4'd0;
	localparam logic [3:0] ACT_ABSENT    = 4'd1;
	localparam logic [3:0] ACT_PERM_OFF  = 4'd2;
	localparam logic [3:0] ACT_HELD      = 4'd3;
	localparam logic [3:0] ACT_CYCLE     = 4'd4;
	localparam logic [3:0] ACT_TIMED     = 4'd5;
	localparam logic [3:0] ACT_PERM      = 4'd6;
	localparam logic [3:0] ACT_CLEARED   = 4'd7;
	localparam logic [3:0] ACT_RECOVERED = 4'd8;
	localparam logic [3:0] ACT_CMD_RESET = 4'd9;

	// request types
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_CLEAR  = 1'b1;

	// configuration register indexes
	localparam logic [2:0] CFG_CHANS    = 3'd0;
	localparam logic [2:0] CFG_EXT_THR  = 3'd1;
	localparam logic [2:0] CFG_PERM_THR = 3'd2;
	localparam logic [2:0] CFG_EXT_MS   = 3'd3;
	localparam logic [2:0] CFG_REC_MS   = 3'd4;

	// per-channel state held in memory
	typedef struct packed {
		logic [7:0]  count;
		logic [31:0] start;
		logic [31:0] deadline;
	} pcfe_entry_t;

	// configuration registers
	typedef struct packed {
		logic [3:0]  chans;
		logic [7:0]  ext_thr;
		logic [7:0]  perm_thr;
		logic [31:0] ext_ms;
		logic [31:0] rec_ms;
	} pcfe_cfg_t;

	// state updates besides the entry itself
	typedef struct packed {
		logic wr_en;
		logic set_prev;
		logic clr_prev;
		logic set_dis;
	} pcfe_upd_t;

	// one result item
	typedef struct packed {
		logic [3:0]  action;
		logic        reenabled;
		logic [7:0]  count;
		logic [31:0] duration;
	} pcfe_result_t;

endpackage

// ===== src/pcfe_state_mem.sv =====
module pcfe_state_mem import pcfe_pkg::*; #(
	parameter int Depth = NumChannelsDef,
	parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [AddrW-1:0] rd_addr,
	output pcfe_entry_t      rd_data,
	input  logic             wr_en,
	input  logic [AddrW-1:0] wr_addr,
	input  pcfe_entry_t      wr_data
);

	pcfe_entry_t mem_q [Depth];
	logic [Depth-1:0] written_q;
	pcfe_entry_t rd_data_q;
	logic rd_written_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// written flags, cleared at reset so unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_written_q ? rd_data_q : '0;

endmodule

// ===== src/pcfe_step.sv =====
module pcfe_step import pcfe_pkg::*; #(
	parameter int NumChannels = NumChannelsDef
) (
	input  logic         req_type,
	input  logic [2:0]   chan,
	input  logic         fault_now,
	input  logic [31:0]  now_ms,
	input  pcfe_cfg_t    cfg,
	input  pcfe_entry_t  entry,
	input  logic         was_fault,
	input  logic         is_disabled,
	output pcfe_entry_t  entry_new,
	output pcfe_upd_t    upd,
	output pcfe_result_t res
);

	logic        in_range;
	logic        esc;
	logic        held;
	logic [31:0] since_dl;
	logic [31:0] since_start;
	logic [31:0] timed_dl;
	logic [7:0]  cnt_inc;

	assign in_range    = 32'(chan) < 32'(NumChannels);
	assign esc         = 32'(chan) < 32'(EscalateLimit);
	assign since_dl    = now_ms - entry.deadline;
	assign since_start = now_ms - entry.start;
	assign timed_dl    = now_ms + cfg.ext_ms;
	assign cnt_inc     = (entry.count == CountMax) ? CountMax : entry.count + 8'd1;

	// one step of the channel supervisor
	always_comb begin
		entry_new     = entry;
		upd           = '0;
		res.action    = ACT_NONE;
		res.reenabled = 1'b0;
		res.duration  = '0;
		held          = 1'b0;
		if (in_range) begin
			upd.wr_en = 1'b1;
			if (req_type == REQ_CLEAR) begin
				if (esc) begin
					entry_new.count = '0;
					entry_new.start = '0;
					res.action      = ACT_CMD_RESET;
				end
			end else if ({1'b0, chan} >= cfg.chans) begin
				res.action = ACT_ABSENT;
			end else if (is_disabled) begin
				res.action = ACT_PERM_OFF;
			end else begin
				// timed disable deadline, wrapping signed compare
				if (entry.deadline != '0) begin
					if (!since_dl[31]) begin
						entry_new.deadline = '0;
						res.reenabled      = 1'b1;
					end else begin
						held       = 1'b1;
						res.action = ACT_HELD;
					end
				end
				if (!held) begin
					if (fault_now && !was_fault) begin
						// rising edge: count and escalate
						entry_new.start = now_ms;
						entry_new.count = cnt_inc;
						upd.set_prev    = 1'b1;
						if (!esc) begin
							res.action = ACT_NONE;
						end else if (cnt_inc >= cfg.perm_thr) begin
							entry_new.deadline = '0;
							upd.set_dis        = 1'b1;
							res.action         = ACT_PERM;
						end else if (cnt_inc >= cfg.ext_thr) begin
							entry_new.deadline = (timed_dl == '0) ? DeadlineFloor : timed_dl;
							res.action         = ACT_TIMED;
						end else begin
							res.action = ACT_CYCLE;
						end
					end else if (!fault_now && was_fault) begin
						// falling edge: report duration
						res.duration = since_start;
						upd.clr_prev = 1'b1;
						res.action   = ACT_CLEARED;
					end else if (!fault_now && entry.count != '0
						&& since_start > cfg.rec_ms) begin
						// healthy long enough
						if (esc) begin
							entry_new.count = '0;
							entry_new.start = '0;
						end
						res.action = ACT_RECOVERED;
					end
				end
			end
		end else if (req_type == REQ_SAMPLE) begin
			res.action = ACT_ABSENT;
		end
		res.count = in_range ? entry_new.count : '0;
	end

endmodule

// ===== src/power_channel_fault_escalator.sv =====
// A result item is written to the output register once its input item's state has been read
// and stepped, unless a waiting result is stalled; the per-channel state memory is read when an
// item is accepted and written back when it completes, and input stalls while that runs.
// A waiting result does not hold up the next item until the write-back must deliver.
// Reset clears fault edges, disable flags and all channel state, and loads the
// register defaults; the entry memory needs no clearing pass.
module power_channel_fault_escalator import pcfe_pkg::*; #(
	parameter int NUM_CHANNELS = NumChannelsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	// input items
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [2:0]  chan,
	input  logic        fault_now,
	input  logic [31:0] now_ms,
	// result items
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  chan_out,
	output logic [3:0]  action,
	output logic        reenabled,
	output logic [7:0]  fault_count_out,
	output logic [31:0] fault_duration_ms
);

	localparam int AddrW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	pcfe_cfg_t cfg_q;
	logic [NUM_CHANNELS-1:0] prev_fault_q;
	logic [NUM_CHANNELS-1:0] disabled_q;

	logic        item_valid_s1;
	logic        req_type_s1;
	logic [2:0]  chan_s1;
	logic        fault_now_s1;
	logic [31:0] now_ms_s1;

	logic         out_valid_q;
	logic [2:0]   chan_out_q;
	pcfe_result_t res_q;

	logic             in_accept;
	logic             done;
	logic             in_range_s1;
	logic [AddrW-1:0] addr_in;
	logic [AddrW-1:0] addr_s1;
	logic             was_fault;
	logic             is_disabled;
	pcfe_entry_t      entry_rd;
	pcfe_entry_t      entry_new;
	pcfe_upd_t        upd;
	pcfe_result_t     res;

	assign cfg_ready   = 1'b1;
	assign in_stall    = item_valid_s1;
	assign in_accept   = in_valid && !in_stall;
	assign done        = item_valid_s1 && (!out_valid_q || !out_stall);
	assign addr_in     = AddrW'(chan);
	assign addr_s1     = AddrW'(chan_s1);
	assign in_range_s1 = 32'(chan_s1) < 32'(NUM_CHANNELS);
	assign was_fault   = in_range_s1 && prev_fault_q[addr_s1];
	assign is_disabled = in_range_s1 && disabled_q[addr_s1];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chans    <= 4'd0;
			cfg_q.ext_thr  <= 8'd2;
			cfg_q.perm_thr <= 8'd3;
			cfg_q.ext_ms   <= 32'd60000;
			cfg_q.rec_ms   <= 32'd300000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CHANS:    cfg_q.chans    <= cfg_data[3:0];
				CFG_EXT_THR:  cfg_q.ext_thr  <= cfg_data[7:0];
				CFG_PERM_THR: cfg_q.perm_thr <= cfg_data[7:0];
				CFG_EXT_MS:   cfg_q.ext_ms   <= cfg_data;
				CFG_REC_MS:   cfg_q.rec_ms   <= cfg_data;
				default: ;
			endcase
		end
	end

	// channel state memory
	pcfe_state_mem #(
		.Depth (NUM_CHANNELS),
		.AddrW (AddrW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_accept),
		.rd_addr (addr_in),
		.rd_data (entry_rd),
		.wr_en   (done && upd.wr_en),
		.wr_addr (addr_s1),
		.wr_data (entry_new)
	);

	// supervisor step
	pcfe_step #(
		.NumChannels (NUM_CHANNELS)
	) u_step (
		.req_type    (req_type_s1),
		.chan        (chan_s1),
		.fault_now   (fault_now_s1),
		.now_ms      (now_ms_s1),
		.cfg         (cfg_q),
		.entry       (entry_rd),
		.was_fault   (was_fault),
		.is_disabled (is_disabled),
		.entry_new   (entry_new),
		.upd         (upd),
		.res         (res)
	);

	// item in flight while the memory is read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_accept) begin
			item_valid_s1 <= 1'b1;
		end else if (done) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_type_s1  <= req_type;
			chan_s1      <= chan;
			fault_now_s1 <= fault_now;
			now_ms_s1    <= now_ms;
		end
	end

	// fault edge and permanent disable flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_fault_q <= '0;
			disabled_q   <= '0;
		end else if (done && in_range_s1) begin
			if (upd.set_prev) begin
				prev_fault_q[addr_s1] <= 1'b1;
			end else if (upd.clr_prev) begin
				prev_fault_q[addr_s1] <= 1'b0;
			end
			if (upd.set_dis) begin
				disabled_q[addr_s1] <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			chan_out_q <= chan_s1;
			res_q      <= res;
		end
	end

	assign out_valid         = out_valid_q;
	assign chan_out          = chan_out_q;
	assign action            = res_q.action;
	assign reenabled         = res_q.reenabled;
	assign fault_count_out   = res_q.count;
	assign fault_duration_ms = res_q.duration;

endmodule

// ===== dv/power_channel_fault_escalator_tb.sv =====
`timescale 1ns / 100ps

module power_channel_fault_escalator_tb;
	import pcfe_pkg::*;

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned PressAt    = 300;
	localparam int unsigned PressLen   = 64;
	localparam int unsigned ShowLimit  = 40;

	// one expected result item
	typedef struct packed {
		logic [2:0]  ch;
		logic [3:0]  act;
		logic        reen;
		logic [7:0]  cnt;
		logic [31:0] dur;
	} outcome_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// one row of the directed script
	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  idx;
		logic [31:0] data;
		logic        req;
		logic [2:0]  ch;
		logic        flt;
		logic [31:0] t;
		logic        typed;
		outcome_t    want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        req_type = REQ_SAMPLE;
	logic [2:0]  chan = '0;
	logic        fault_now = 1'b0;
	logic [31:0] now_ms = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  chan_out;
	logic [3:0]  action;
	logic        reenabled;
	logic [7:0]  fault_count_out;
	logic [31:0] fault_duration_ms;

	// supervisor state as predicted
	logic [7:0]  rail_prev;
	logic [7:0]  rail_killed;
	logic [7:0]  rail_count [8];
	logic [31:0] rail_start [8];
	logic [31:0] rail_deadline [8];

	// register contents as predicted
	logic [3:0]  reg_chans;
	logic [7:0]  reg_ext_thr;
	logic [7:0]  reg_perm_thr;
	logic [31:0] reg_ext_ms;
	logic [31:0] reg_rec_ms;

	outcome_t    pending_outcomes [$];
	dir_row_t    script [$];
	logic [31:0] clock_ms;
	logic        calm = 1'b0;
	int unsigned errors = 0;
	int unsigned taken_in = 0;
	int unsigned cycle_count = 0;
	int unsigned rx_gap = 0;
	int unsigned press_left = 0;
	logic        pressed = 1'b0;

	power_channel_fault_escalator dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.req_type         (req_type),
		.chan             (chan),
		.fault_now        (fault_now),
		.now_ms           (now_ms),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.chan_out         (chan_out),
		.action           (action),
		.reenabled        (reenabled),
		.fault_count_out  (fault_count_out),
		.fault_duration_ms(fault_duration_ms)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted outcome of one item, updating the predicted state
	function automatic outcome_t supervise(input logic rq, input logic [2:0] c,
			input logic f, input logic [31:0] t);
		outcome_t    o;
		logic        held;
		logic [31:0] lag;
		logic [31:0] due;
		o = '0;
		o.ch = c;
		o.act = ACT_NONE;
		held = 1'b0;
		if (rq == REQ_CLEAR) begin
			if (c < EscalateLimit) begin
				rail_count[c] = '0;
				rail_start[c] = '0;
				o.act = ACT_CMD_RESET;
			end
		end else if ({1'b0, c} >= reg_chans) begin
			o.act = ACT_ABSENT;
		end else if (rail_killed[c]) begin
			o.act = ACT_PERM_OFF;
		end else begin
			// timed disable, wrapping signed compare
			if (rail_deadline[c] != '0) begin
				lag = t - rail_deadline[c];
				if (!lag[31]) begin
					rail_deadline[c] = '0;
					o.reen = 1'b1;
				end else begin
					held = 1'b1;
					o.act = ACT_HELD;
				end
			end
			if (!held) begin
				lag = t - rail_start[c];
				if (f && !rail_prev[c]) begin
					// rising edge: count and escalate
					rail_start[c] = t;
					if (rail_count[c] != CountMax)
						rail_count[c] = rail_count[c] + 8'd1;
					rail_prev[c] = 1'b1;
					if (c >= EscalateLimit) begin
						o.act = ACT_NONE;
					end else if (rail_count[c] >= reg_perm_thr) begin
						rail_deadline[c] = '0;
						rail_killed[c] = 1'b1;
						o.act = ACT_PERM;
					end else if (rail_count[c] >= reg_ext_thr) begin
						due = t + reg_ext_ms;
						rail_deadline[c] = (due == '0) ? DeadlineFloor : due;
						o.act = ACT_TIMED;
					end else begin
						o.act = ACT_CYCLE;
					end
				end else if (!f && rail_prev[c]) begin
					o.dur = lag;
					rail_prev[c] = 1'b0;
					o.act = ACT_CLEARED;
				end else if (!f && rail_count[c] != '0 && lag > reg_rec_ms) begin
					if (c < EscalateLimit) begin
						rail_count[c] = '0;
						rail_start[c] = '0;
					end
					o.act = ACT_RECOVERED;
				end
			end
		end
		o.cnt = rail_count[c];
		return o;
	endfunction

	// script rows
	function automatic dir_row_t cfg_row(input logic [2:0] idx, input logic [31:0] data);
		dir_row_t r;
		r = '0;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	function automatic dir_row_t item_row(input logic rq, input logic [2:0] c, input logic f,
			input logic [31:0] t);
		dir_row_t r;
		r = '0;
		r.kind = ROW_ITEM;
		r.req = rq;
		r.ch = c;
		r.flt = f;
		r.t = t;
		return r;
	endfunction

	function automatic dir_row_t known_row(input logic rq, input logic [2:0] c, input logic f,
			input logic [31:0] t, input logic [3:0] act, input logic reen,
			input logic [7:0] cnt, input logic [31:0] dur);
		dir_row_t r;
		r = item_row(rq, c, f, t);
		r.typed = 1'b1;
		r.want.ch = c;
		r.want.act = act;
		r.want.reen = reen;
		r.want.cnt = cnt;
		r.want.dur = dur;
		return r;
	endfunction

	// register write, valid left high for a following write
	task automatic load_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_CHANS:    reg_chans = data[3:0];
			CFG_EXT_THR:  reg_ext_thr = data[7:0];
			CFG_PERM_THR: reg_perm_thr = data[7:0];
			CFG_EXT_MS:   reg_ext_ms = data;
			CFG_REC_MS:   reg_rec_ms = data;
			default: ;
		endcase
	endtask

	// drain every outstanding result, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// offer one item and record what it should produce
	task automatic send_item(input logic rq, input logic [2:0] c, input logic f,
			input logic [31:0] t, input logic typed, input outcome_t known);
		outcome_t    o;
		int unsigned gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		chan <= c;
		fault_now <= f;
		now_ms <= t;
		do @(posedge clk); while (in_stall);
		o = supervise(rq, c, f, t);
		pending_outcomes.push_back(typed ? known : o);
	endtask

	task automatic retune(input logic [3:0] chans, input logic [7:0] ext_thr,
			input logic [7:0] perm_thr, input logic [31:0] ext_ms, input logic [31:0] rec_ms);
		settle();
		load_reg(CFG_CHANS, {28'd0, chans});
		load_reg(CFG_EXT_THR, {24'd0, ext_thr});
		load_reg(CFG_PERM_THR, {24'd0, perm_thr});
		load_reg(CFG_EXT_MS, ext_ms);
		load_reg(CFG_REC_MS, rec_ms);
		// unused index, no effect
		load_reg(3'(CFG_REC_MS + $urandom_range(1, 3)), $urandom);
		cfg_valid <= 1'b0;
	endtask

	// millisecond span, extremes included
	function automatic logic [31:0] pick_span(input int unsigned cap);
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return 32'hFFFF_FFFF;
			2: return $urandom;
			default: return $urandom_range(1, cap);
		endcase
	endfunction

	// mostly plausible edges on connected channels, some commands and noise
	task automatic send_random();
		int unsigned roll;
		int unsigned hop;
		logic        rq;
		logic [2:0]  c;
		logic        f;
		logic [31:0] t;
		roll = $urandom_range(0, 99);
		hop = $urandom_range(0, 99);
		if (hop < 70)
			clock_ms += $urandom_range(0, 3000);
		else if (hop < 92)
			clock_ms += $urandom_range(3000, 400000);
		else
			clock_ms += $urandom;
		rq = REQ_SAMPLE;
		t = clock_ms;
		if (roll < 8) begin
			rq = REQ_CLEAR;
			c = 3'($urandom_range(0, 7));
			f = 1'($urandom_range(0, 1));
		end else if (roll < 14) begin
			c = 3'($urandom_range(0, 7));
			f = 1'($urandom_range(0, 1));
			t = $urandom;
		end else begin
			c = (reg_chans == '0) ? 3'($urandom_range(0, 7)) :
				3'($urandom_range(0, reg_chans - 1));
			f = ($urandom_range(0, 2) != 0) ? !rail_prev[c] : rail_prev[c];
		end
		send_item(rq, c, f, t, 1'b0, '0);
	endtask

	task automatic match_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= ShowLimit)
				$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	// result checking and accepted item count
	always @(posedge clk) begin : check_results
		outcome_t head;
		if (arst_n && in_valid && !in_stall)
			taken_in <= taken_in + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outcomes.size() == 0) begin
				errors++;
				if (errors <= ShowLimit)
					$display("%0t: result item with none expected, chan %0d action %0d",
						$time, chan_out, action);
			end else begin
				head = pending_outcomes.pop_front();
				match_field("chan_out", {29'd0, head.ch}, {29'd0, chan_out});
				match_field("action", {28'd0, head.act}, {28'd0, action});
				match_field("reenabled", {31'd0, head.reen}, {31'd0, reenabled});
				match_field("fault_count_out", {24'd0, head.cnt}, {24'd0, fault_count_out});
				match_field("fault_duration_ms", head.dur, fault_duration_ms);
			end
		end
	end

	// receiver: short random stalls, one long hold to back the block up
	always @(posedge clk) begin
		if (!pressed && taken_in >= PressAt) begin
			out_stall <= 1'b1;
			press_left <= PressLen;
			pressed <= 1'b1;
		end else if (press_left > 0) begin
			out_stall <= 1'b1;
			press_left <= press_left - 1;
		end else if (rx_gap > 0) begin
			out_stall <= 1'b1;
			rx_gap <= rx_gap - 1;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			rx_gap <= $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("power_channel_fault_escalator_tb: done, errors");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned k;
		int unsigned p;
		// predicted state after reset
		rail_prev = '0;
		rail_killed = '0;
		foreach (rail_count[i]) begin
			rail_count[i] = '0;
			rail_start[i] = '0;
			rail_deadline[i] = '0;
		end
		reg_chans = 4'd0;
		reg_ext_thr = 8'd2;
		reg_perm_thr = 8'd3;
		reg_ext_ms = 32'd60000;
		reg_rec_ms = 32'd300000;

		// directed script: reset defaults, escalation ladder, upper channels
		script.push_back(known_row(REQ_SAMPLE, 3'd0, 1'b1, 32'd0, ACT_ABSENT, 1'b0, 8'd0, 32'd0));
		script.push_back(known_row(REQ_SAMPLE, 3'd7, 1'b0, 32'hFFFF_FFFF, ACT_ABSENT, 1'b0,
			8'd0, 32'd0));
		script.push_back(known_row(REQ_CLEAR, 3'd0, 1'b0, 32'd0, ACT_CMD_RESET, 1'b0, 8'd0, 32'd0));
		script.push_back(known_row(REQ_CLEAR, 3'd7, 1'b1, 32'hFFFF_FFFF, ACT_NONE, 1'b0,
			8'd0, 32'd0));
		script.push_back(cfg_row(CFG_CHANS, 32'd8));
		script.push_back(known_row(REQ_SAMPLE, 3'd0, 1'b1, 32'd100, ACT_CYCLE, 1'b0, 8'd1, 32'd0));
		script.push_back(known_row(REQ_SAMPLE, 3'd0, 1'b0, 32'd350, ACT_CLEARED, 1'b0,
			8'd1, 32'd250));
		script.push_back(known_row(REQ_SAMPLE, 3'd0, 1'b1, 32'd400, ACT_TIMED, 1'b0, 8'd2, 32'd0));
		script.push_back(known_row(REQ_SAMPLE, 3'd0, 1'b0, 32'd500, ACT_HELD, 1'b0, 8'd2, 32'd0));
		script.push_back(known_row(REQ_SAMPLE, 3'd0, 1'b0, 32'd60400, ACT_CLEARED, 1'b1,
			8'd2, 32'd60000));
		script.push_back(known_row(REQ_SAMPLE, 3'd0, 1'b1, 32'd60500, ACT_PERM, 1'b0, 8'd3, 32'd0));
		script.push_back(known_row(REQ_SAMPLE, 3'd0, 1'b0, 32'd60600, ACT_PERM_OFF, 1'b0,
			8'd3, 32'd0));
		script.push_back(known_row(REQ_CLEAR, 3'd0, 1'b0, 32'd0, ACT_CMD_RESET, 1'b0, 8'd0, 32'd0));
		script.push_back(known_row(REQ_SAMPLE, 3'd6, 1'b1, 32'd0, ACT_NONE, 1'b0, 8'd1, 32'd0));
		script.push_back(known_row(REQ_SAMPLE, 3'd6, 1'b0, 32'd10, ACT_CLEARED, 1'b0,
			8'd1, 32'd10));
		script.push_back(known_row(REQ_SAMPLE, 3'd6, 1'b0, 32'd400000, ACT_RECOVERED, 1'b0,
			8'd1, 32'd0));
		script.push_back(known_row(REQ_CLEAR, 3'd6, 1'b0, 32'd0, ACT_NONE, 1'b0, 8'd1, 32'd0));
		// deadline that wraps onto zero, then held across the wrap
		script.push_back(cfg_row(CFG_EXT_THR, 32'd1));
		script.push_back(cfg_row(CFG_PERM_THR, 32'd255));
		script.push_back(cfg_row(CFG_EXT_MS, 32'h0001_0000));
		script.push_back(cfg_row(CFG_REC_MS, 32'd0));
		script.push_back(item_row(REQ_SAMPLE, 3'd1, 1'b1, 32'hFFFF_0000));
		script.push_back(item_row(REQ_SAMPLE, 3'd1, 1'b0, 32'd0));
		script.push_back(item_row(REQ_SAMPLE, 3'd1, 1'b0, 32'd1));
		script.push_back(item_row(REQ_SAMPLE, 3'd2, 1'b1, 32'h8000_0000));
		script.push_back(item_row(REQ_SAMPLE, 3'd2, 1'b0, 32'h8000_0001));
		// zero-length timed disable and an immediate recovery
		script.push_back(cfg_row(CFG_EXT_MS, 32'd0));
		script.push_back(item_row(REQ_SAMPLE, 3'd3, 1'b1, 32'd10));
		script.push_back(item_row(REQ_SAMPLE, 3'd3, 1'b0, 32'd11));
		script.push_back(item_row(REQ_SAMPLE, 3'd3, 1'b0, 32'd12));

		// reset
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// walk the script
		foreach (script[i]) begin
			if (script[i].kind == ROW_CFG) begin
				if (!cfg_valid)
					settle();
				load_reg(script[i].idx, script[i].data);
			end else begin
				if (cfg_valid)
					cfg_valid <= 1'b0;
				send_item(script[i].req, script[i].ch, script[i].flt, script[i].t,
					script[i].typed, script[i].want);
			end
		end

		// saturate an upper channel's counter with upper extremes loaded
		clock_ms = $urandom;
		retune(4'd8, 8'd255, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		for (k = 0; k < 256; k++) begin
			clock_ms += $urandom_range(1, 50);
			send_item(REQ_SAMPLE, 3'd7, 1'b1, clock_ms, 1'b0, '0);
			clock_ms += $urandom_range(1, 50);
			send_item(REQ_SAMPLE, 3'd7, 1'b0, clock_ms, 1'b0, '0);
		end

		// random phases, each under its own settings
		for (p = 0; p < 7; p++) begin
			case (p)
				0: retune(4'd0, 8'd1, 8'd255, 32'd0, 32'd0);
				6: begin
					calm <= 1'b1;
					retune(4'd8, 8'd2, 8'd1, 32'd1000, 32'd5000);
				end
				default: retune(4'($urandom_range(1, 8)), 8'($urandom_range(1, 4)),
					8'($urandom_range(8, 255)), pick_span(5000), pick_span(30000));
			endcase
			for (k = 0; k < 100; k++)
				send_random();
		end

		settle();
		if (errors == 0 && pending_outcomes.size() == 0)
			$display("power_channel_fault_escalator_tb: done, clean");
		else
			$display("power_channel_fault_escalator_tb: done, errors");
		$finish;
	end

endmodule

// ===== power_channel_fault_escalator.f =====
src/pcfe_pkg.sv
src/pcfe_state_mem.sv
src/pcfe_step.sv
src/power_channel_fault_escalator.sv
dv/power_channel_fault_escalator_tb.sv
